### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the serial packet deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spd_pkg.sv
// Types and constants shared by the serial packet deframer modules.
package spd_pkg;

    localparam int BYTE_W = 8;

    // Register select bit of the configuration address.
    localparam logic REG_SYNC = 1'b0;
    localparam logic REG_MASK = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] MASK_RESET = 8'h55;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] rx_sum;
        logic              sum_ok;
    } t_record;

endpackage

### rtl/spd_fsm.sv
// Framing state machine: tracks the packet phase, header fields and running sum.
module spd_fsm
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_flush,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_sync_byte,
    input  logic [BYTE_W-1:0] i_sum_mask,
    output t_record           o_rec
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_ADDR    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_CMD     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_SUM     = 3'd5;

    logic [2:0]        r_phase,   n_phase;
    logic [BYTE_W-1:0] r_address, n_address;
    logic [BYTE_W-1:0] r_length,  n_length;
    logic [BYTE_W-1:0] r_command, n_command;
    logic [BYTE_W-1:0] r_count,   n_count;
    logic [BYTE_W-1:0] r_sum,     n_sum;
    logic [BYTE_W-1:0] w_sum_add;
    logic [BYTE_W-1:0] w_count_inc;

    assign w_sum_add   = r_sum + i_byte;
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_address = r_address;
        n_length  = r_length;
        n_command = r_command;
        n_count   = r_count;
        n_sum     = r_sum;

        o_rec         = '0;
        o_rec.address = r_address;
        o_rec.command = r_command;
        o_rec.length  = r_length;

        if (i_flush) begin
            n_phase   = PH_HUNT;
            n_address = '0;
            n_length  = '0;
            n_command = '0;
            n_count   = '0;
            n_sum     = '0;
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_sync_byte) begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    n_address = i_byte;
                    n_sum     = i_byte;
                    n_phase   = PH_LEN;
                end
                PH_LEN: begin
                    n_length = i_byte;
                    n_sum    = w_sum_add;
                    n_phase  = PH_CMD;
                end
                PH_CMD: begin
                    n_command = i_byte;
                    n_sum     = w_sum_add;
                    n_count   = '0;
                    n_phase   = (r_length == '0) ? PH_SUM : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_rec.valid   = 1'b1;
                    o_rec.kind    = KIND_PAYLOAD;
                    o_rec.index   = r_count;
                    o_rec.payload = i_byte;
                    n_sum         = w_sum_add;
                    n_count       = w_count_inc;
                    if (w_count_inc == r_length) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    o_rec.valid  = 1'b1;
                    o_rec.kind   = KIND_END;
                    o_rec.rx_sum = i_byte;
                    o_rec.sum_ok = (i_byte == (r_sum ^ i_sum_mask));
                    n_phase      = PH_HUNT;
                end
                default: begin
                    n_phase   = PH_HUNT;
                    n_address = '0;
                    n_length  = '0;
                    n_command = '0;
                    n_count   = '0;
                    n_sum     = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_address <= '0;
            r_length  <= '0;
            r_command <= '0;
            r_count   <= '0;
            r_sum     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_address <= n_address;
            r_length  <= n_length;
            r_command <= n_command;
            r_count   <= n_count;
            r_sum     <= n_sum;
        end
    end

endmodule

### rtl/serial_packet_deframer.sv
// Top level of the serial packet deframer: input register, framing logic, result register.
// The block takes one received word or flush request per clock cycle and recovers packets
// framed as sync byte, address, length, command, payload bytes and checksum. A word is
// held in an input register, passes through the framing logic and lands in a result
// register. The rate is one word per cycle, as the phase and running sum are updated once
// per word; the input side stalls only while a finished result waits to be taken.
// Registers: sync byte at address 0 (reset 0xAA) and checksum mask at address 4 (reset 0x55).
`include "assert_macros.svh"

module serial_packet_deframer
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_record_kind,
    output logic [7:0]        o_pkt_address,
    output logic [7:0]        o_pkt_command,
    output logic [7:0]        o_pkt_length,
    output logic [7:0]        o_byte_index,
    output logic [7:0]        o_payload_byte,
    output logic [7:0]        o_received_sum,
    output logic              o_sum_ok,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] r_sync;
    logic [BYTE_W-1:0] r_mask;
    logic              w_cfg_write;

    logic              r_in_valid;
    logic              r_req_type;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              w_step;

    t_record           w_rec;
    t_record           r_out;
    logic              r_out_valid;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;
    assign prdata      = (paddr[2] == REG_MASK) ? {24'd0, r_mask} : {24'd0, r_sync};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_mask <= MASK_RESET;
        end else if (w_cfg_write) begin
            if (paddr[2] == REG_SYNC) begin
                r_sync <= pwdata[BYTE_W-1:0];
            end else begin
                r_mask <= pwdata[BYTE_W-1:0];
            end
        end
    end

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req_type <= i_req_type;
            r_rx_byte  <= i_rx_byte;
        end
    end

    spd_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_flush     (r_req_type),
        .i_byte      (r_rx_byte),
        .i_sync_byte (r_sync),
        .i_sum_mask  (r_mask),
        .o_rec       (w_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_rec.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_rec.valid) begin
            r_out <= w_rec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_out.kind;
    assign o_pkt_address  = r_out.address;
    assign o_pkt_command  = r_out.command;
    assign o_pkt_length   = r_out.length;
    assign o_byte_index   = r_out.index;
    assign o_payload_byte = r_out.payload;
    assign o_received_sum = r_out.rx_sum;
    assign o_sum_ok       = r_out.sum_ok;

    `ASSERT_ALWAYS(a_payload_index, i_clk, i_rst_n, !(o_out_valid && (o_record_kind == KIND_PAYLOAD)) || (o_byte_index < o_pkt_length), "Payload index is not below the packet length.")
    `ASSERT_ALWAYS(a_payload_no_sum, i_clk, i_rst_n, !(o_out_valid && (o_record_kind == KIND_PAYLOAD)) || ((o_received_sum == 8'd0) && !o_sum_ok), "Payload record carries checksum fields.")
    `ASSERT_NEXT(a_stall_holds_word, i_clk, i_rst_n, r_in_valid && !w_step, r_in_valid && $stable(r_rx_byte) && $stable(r_req_type), "Stalled word was lost or changed.")

endmodule

### bench/testbench.sv
// Self-checking testbench for the serial packet deframer with a built-in framing predictor.
module testbench;
    import spd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [2:0] ADDR_SYNC = {REG_SYNC, 2'b00};
    localparam logic [2:0] ADDR_MASK = {REG_MASK, 2'b00};

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        HUNT, GET_ADDR, GET_LEN, GET_CMD, GET_PAYLOAD, GET_SUM
    } t_frame_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_record_kind;
    logic [7:0]  o_pkt_address;
    logic [7:0]  o_pkt_command;
    logic [7:0]  o_pkt_length;
    logic [7:0]  o_byte_index;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_received_sum;
    logic        o_sum_ok;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and its copy of the configuration.
    logic [7:0]   sync_val;
    logic [7:0]   mask_val;
    t_frame_phase frame_phase;
    logic [7:0]   cur_addr;
    logic [7:0]   cur_len;
    logic [7:0]   cur_cmd;
    logic [7:0]   pay_count;
    logic [7:0]   run_sum;

    t_record pending_records[$];
    t_record got_rec;
    t_record want_rec;

    int  fail_count;
    int  items_sent;
    int  cycle_count;
    int  ready_run;
    int  send_quiet;
    bit  idle_on;

    serial_packet_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_record_kind  (o_record_kind),
        .o_pkt_address  (o_pkt_address),
        .o_pkt_command  (o_pkt_command),
        .o_pkt_length   (o_pkt_length),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_received_sum (o_received_sum),
        .o_sum_ok       (o_sum_ok),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Advances the framing state by one accepted word and queues any record it causes.
    function automatic void advance_deframer(input logic flush, input logic [7:0] b);
        t_record rec;
        rec = '0;
        rec.valid = 1'b1;
        if (flush) begin
            frame_phase = HUNT;
            cur_addr = '0;
            cur_len = '0;
            cur_cmd = '0;
            pay_count = '0;
            run_sum = '0;
        end else begin
            case (frame_phase)
                HUNT: begin
                    if (b == sync_val) frame_phase = GET_ADDR;
                end
                GET_ADDR: begin
                    cur_addr = b;
                    run_sum = b;
                    frame_phase = GET_LEN;
                end
                GET_LEN: begin
                    cur_len = b;
                    run_sum = run_sum + b;
                    frame_phase = GET_CMD;
                end
                GET_CMD: begin
                    cur_cmd = b;
                    run_sum = run_sum + b;
                    pay_count = '0;
                    frame_phase = (cur_len == 8'd0) ? GET_SUM : GET_PAYLOAD;
                end
                GET_PAYLOAD: begin
                    rec.kind = KIND_PAYLOAD;
                    rec.address = cur_addr;
                    rec.command = cur_cmd;
                    rec.length = cur_len;
                    rec.index = pay_count;
                    rec.payload = b;
                    pending_records.push_back(rec);
                    run_sum = run_sum + b;
                    pay_count = pay_count + 8'd1;
                    if (pay_count == cur_len) frame_phase = GET_SUM;
                end
                GET_SUM: begin
                    rec.kind = KIND_END;
                    rec.address = cur_addr;
                    rec.command = cur_cmd;
                    rec.length = cur_len;
                    rec.rx_sum = b;
                    rec.sum_ok = (b == (run_sum ^ mask_val));
                    pending_records.push_back(rec);
                    frame_phase = HUNT;
                end
                default: frame_phase = HUNT;
            endcase
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_rec.valid = 1'b1;
            got_rec.kind = o_record_kind;
            got_rec.address = o_pkt_address;
            got_rec.command = o_pkt_command;
            got_rec.length = o_pkt_length;
            got_rec.index = o_byte_index;
            got_rec.payload = o_payload_byte;
            got_rec.rx_sum = o_received_sum;
            got_rec.sum_ok = o_sum_ok;
            if (pending_records.size() == 0) begin
                note_failure($sformatf("Unexpected record: kind %0d addr %02h index %0d",
                    o_record_kind, o_pkt_address, o_byte_index));
            end else begin
                want_rec = pending_records.pop_front();
                if (got_rec !== want_rec) begin
                    note_failure($sformatf({"Record mismatch: expected kind %0d addr %02h ",
                        "cmd %02h len %02h index %0d byte %02h sum %02h ok %0d; got kind %0d ",
                        "addr %02h cmd %02h len %02h index %0d byte %02h sum %02h ok %0d"},
                        want_rec.kind, want_rec.address, want_rec.command, want_rec.length,
                        want_rec.index, want_rec.payload, want_rec.rx_sum, want_rec.sum_ok,
                        got_rec.kind, got_rec.address, got_rec.command, got_rec.length,
                        got_rec.index, got_rec.payload, got_rec.rx_sum, got_rec.sum_ok));
                end
            end
        end
    end

    // With idle_on set, the result side stalls in bursts between runs of steady readiness.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_ready = 1'b1;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_ready = 1'b0;
            ready_run = $urandom_range(1, 16) - 1;
        end else begin
            i_out_ready = 1'b1;
            ready_run = $urandom_range(1, 40) - 1;
        end
    end

    task automatic send_word(input logic flush, input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_on) begin
            if (send_quiet > 0) begin
                send_quiet--;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 16);
            end else begin
                send_quiet = $urandom_range(0, 30);
            end
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = flush;
        i_rx_byte = b;
        do @(posedge i_clk); while (!o_in_ready);
        if (flush || frame_phase != HUNT || b == sync_val) items_sent++;
        advance_deframer(flush, b);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_SYNC) sync_val = value;
        else mask_val = value;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [7:0] value);
        logic [31:0] data;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (data !== {24'd0, value}) begin
            note_failure($sformatf("Register %0d read: expected %08h got %08h",
                addr, {24'd0, value}, data));
        end
    endtask

    task automatic set_config(input logic [7:0] sync_in, input logic [7:0] mask_in);
        reg_write(ADDR_SYNC, sync_in);
        reg_write(ADDR_MASK, mask_in);
        reg_check(ADDR_SYNC, sync_in);
        reg_check(ADDR_MASK, mask_in);
    endtask

    // A negative fill gives random payload bytes.
    task automatic send_packet(input logic [7:0] addr, input logic [7:0] len,
                               input logic [7:0] cmd, input int fill, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        send_word(REQ_BYTE, sync_val);
        send_word(REQ_BYTE, addr);
        send_word(REQ_BYTE, len);
        send_word(REQ_BYTE, cmd);
        sum = addr + len + cmd;
        for (i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            sum = sum + b;
            send_word(REQ_BYTE, b);
        end
        sum = sum ^ mask_val;
        if (bad_sum) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_word(REQ_BYTE, sum);
    endtask

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(0, 6));
        if (r < 97) return 8'($urandom_range(7, 32));
        return 8'($urandom_range(33, 80));
    endfunction

    task automatic send_noise();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == sync_val);
        send_word(REQ_BYTE, b);
    endtask

    task automatic run_traffic(input int n_items);
        int target;
        int r;
        int k;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_packet(8'($urandom_range(0, 255)), pick_length(),
                    8'($urandom_range(0, 255)), -1, ($urandom_range(0, 4) == 0));
            end else if (r < 82) begin
                send_noise();
            end else if (r < 90) begin
                send_word(REQ_FLUSH, 8'($urandom_range(0, 255)));
            end else begin
                // A packet cut short by a flush request.
                send_word(REQ_BYTE, sync_val);
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    send_word(REQ_BYTE, 8'($urandom_range(0, 255)));
                end
                send_word(REQ_FLUSH, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_register_defaults();
        reg_check(ADDR_SYNC, SYNC_RESET);
        reg_check(ADDR_MASK, MASK_RESET);
    endtask

    task automatic test_directed_cases();
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_packet(8'h00, 8'h00, 8'hFF, -1, 1'b0);
        send_packet(sync_val, 8'h02, sync_val, sync_val, 1'b1);
        send_packet(8'hFF, 8'h01, 8'h00, 8'hFF, 1'b0);
        send_word(REQ_BYTE, sync_val);
        send_word(REQ_BYTE, 8'h12);
        send_word(REQ_BYTE, 8'h03);
        send_word(REQ_BYTE, 8'h01);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_FLUSH, 8'hFF);
    endtask

    task automatic test_random_traffic();
        run_traffic(500);
    endtask

    task automatic test_config_extremes();
        wait_drained();
        set_config(8'h00, 8'h00);
        run_traffic(250);
        wait_drained();
        set_config(8'hFF, 8'hFF);
        run_traffic(250);
        wait_drained();
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_traffic(250);
        wait_drained();
        set_config(SYNC_RESET, MASK_RESET);
    endtask

    task automatic test_long_packets();
        send_packet(8'($urandom_range(0, 255)), 8'd255, 8'($urandom_range(0, 255)), -1, 1'b0);
        send_packet(8'($urandom_range(0, 255)), 8'd254, 8'($urandom_range(0, 255)), -1, 1'b1);
    endtask

    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 6; n++) begin
            send_packet(8'($urandom_range(0, 255)), pick_length(),
                8'($urandom_range(0, 255)), -1, (n == 3));
            wait_drained();
        end
    endtask

    task automatic test_final_no_idle();
        idle_on = 1'b0;
        run_traffic(250);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_BYTE;
        i_rx_byte = 8'd0;
        i_out_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_SYNC;
        pwdata = 32'd0;
        fail_count = 0;
        items_sent = 0;
        cycle_count = 0;
        ready_run = 0;
        send_quiet = 0;
        idle_on = 1'b1;
        sync_val = SYNC_RESET;
        mask_val = MASK_RESET;
        frame_phase = HUNT;
        cur_addr = '0;
        cur_len = '0;
        cur_cmd = '0;
        pay_count = '0;
        run_sum = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_defaults();
        test_directed_cases();
        test_random_traffic();
        test_config_extremes();
        test_long_packets();
        test_drain_pause();
        test_final_no_idle();

        wait_drained();
        if (fail_count == 0 && pending_records.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
